// File: hdl/tgarle_pkg.sv
`default_nettype none

package tgarle_pkg;

   // Field widths of the stream and result items.
   localparam int BYTE_WIDTH  = 8;
   localparam int PIXEL_WIDTH = 32;
   localparam int RUN_WIDTH   = 8;
   localparam int BPP_WIDTH   = 3;
   localparam int TOTAL_WIDTH = 32;

   // Configuration register indexes.
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BYTES_PER_PIXEL = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TOTAL_PIXELS    = 2'd1;
   localparam logic [BPP_WIDTH-1:0]       BPP_RESET           = 3'd4;

   // Depth of the command queue between the front and the back.
   localparam int CMD_DEPTH     = 2;
   localparam int CMD_PTR_WIDTH = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_WIDTH = $clog2(CMD_DEPTH + 1);

   // One compressed stream byte.
   typedef struct packed {
      logic [BYTE_WIDTH-1:0] stream_byte;
      logic                  image_start;
   } req_type;

   // One result: up to two pixels.
   typedef struct packed {
      logic [PIXEL_WIDTH-1:0] pixel_first;
      logic [PIXEL_WIDTH-1:0] pixel_second;
      logic [1:0]             pixel_count;
      logic                   last_of_packet;
      logic                   image_done;
   } rsp_type;

   // One pixel to be emitted a number of times (a raw pixel has a count of one).
   typedef struct packed {
      logic [PIXEL_WIDTH-1:0] pixel;
      logic [RUN_WIDTH-1:0]   count;
      logic                   image_done;
   } cmd_type;

   // Command queue head as seen by the back.
   typedef struct packed {
      logic    valid;
      cmd_type data;
   } cmd_head_type;

endpackage

`default_nettype wire

// File: hdl/tga_rle_pixel_decoder.sv
// TGA run-length pixel decoder.
// Request channel: one compressed stream byte per request, written with req_push
// while req_full is low. Set image_start on the first packet header of an image.
// Result channel: while rsp_empty is low, rsp_data holds the oldest result (one or
// two pixels); rsp_pop takes it. Results leave in stream order.
// Configuration: csr_valid writes csr_wdata to register csr_index (0 is bytes per
// pixel, 1 is total pixels); csr_ready is always high. Write only while idle.
// Path: a completed pixel goes through the command queue and then the output
// register before it shows on the result ports.
// Throughput: the front takes one byte per cycle while its two-entry command
// queue has room. A run of N pixels becomes ceil(N/2) results, one per cycle while
// the receiver takes them, and the front keeps accepting bytes until the queue fills.
// Each raw pixel leaves as a result of its own.
// When the receiver stalls, the output register holds its result, the queue
// fills, and req_full rises; nothing is dropped.
// Reset clears the queue and the output register, sets bytes per pixel to 4 and
// total pixels to 0; bytes are then ignored until an image_start request.
`default_nettype none

module tga_rle_pixel_decoder
   import tgarle_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_push,
   input  wire req_type                    req_data,
   output logic                            req_full,
   output logic                            rsp_empty,
   output rsp_type                         rsp_data,
   input  wire logic                       rsp_pop,
   input  wire logic                       csr_valid,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [TOTAL_WIDTH-1:0]     csr_wdata,
   output logic                            csr_ready
);

   logic         cmd_push;
   cmd_type      cmd_data;
   logic         cmd_full;
   cmd_head_type cmd_head;
   logic         cmd_pop;

   // Byte parsing and packet bookkeeping.
   tgarle_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr_ready (csr_ready),
      .cmd_push  (cmd_push),
      .cmd_data  (cmd_data),
      .cmd_full  (cmd_full)
   );

   // Queue of pixels with repeat counts.
   tgarle_cmd_fifo u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .cmd_push (cmd_push),
      .cmd_data (cmd_data),
      .cmd_full (cmd_full),
      .cmd_head (cmd_head),
      .cmd_pop  (cmd_pop)
   );

   // Run expansion into results.
   tgarle_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_head  (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data),
      .rsp_pop   (rsp_pop)
   );

   // The front never pushes a command into a full queue.
   assert property (@(posedge clock) disable iff (reset) cmd_push |-> !cmd_full)
      else $error("command pushed into a full queue");

   // No result is pending right after reset.
   assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result pending after reset");

   // A pending result carries one or two pixels.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.pixel_count == 2'd1 || rsp_data.pixel_count == 2'd2))
      else $error("bad pixel count");

   // The last pixel of the image always closes a packet.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.image_done) |-> rsp_data.last_of_packet)
      else $error("image done without end of packet");

endmodule

`default_nettype wire

// File: hdl/tgarle_front.sv
`default_nettype none

module tgarle_front
   import tgarle_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_push,
   input  wire req_type                    req_data,
   output logic                            req_full,
   input  wire logic                       csr_valid,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [TOTAL_WIDTH-1:0]     csr_wdata,
   output logic                            csr_ready,
   output logic                            cmd_push,
   output cmd_type                         cmd_data,
   input  wire logic                       cmd_full
);

   localparam logic [1:0] PH_DONE   = 2'd0;
   localparam logic [1:0] PH_HEADER = 2'd1;
   localparam logic [1:0] PH_RUN    = 2'd2;
   localparam logic [1:0] PH_RAW    = 2'd3;

   logic [BPP_WIDTH-1:0]   bpp_ff, bpp_in;
   logic [TOTAL_WIDTH-1:0] total_ff, total_in;
   logic [1:0]             phase_ff, phase_in;
   logic [RUN_WIDTH-1:0]   packet_left_ff, packet_left_in;
   logic [1:0]             byte_index_ff, byte_index_in;
   logic [PIXEL_WIDTH-1:0] assembly_ff, assembly_in;
   logic [TOTAL_WIDTH-1:0] image_left_ff, image_left_in;

   logic                   accept;
   logic                   bpp_ok;
   logic [1:0]             phase_v;
   logic [TOTAL_WIDTH-1:0] image_left_v;
   logic [RUN_WIDTH-1:0]   header_count;
   logic [PIXEL_WIDTH-1:0] assembly_next;
   logic [1:0]             index_next;
   logic                   pixel_complete;
   logic [TOTAL_WIDTH-1:0] image_left_after;
   logic [RUN_WIDTH-1:0]   packet_left_after;

   assign csr_ready = 1'b1;
   assign req_full  = cmd_full;
   assign accept    = req_push && !req_full;
   assign bpp_ok    = (bpp_ff >= BPP_WIDTH'(1)) && (bpp_ff <= BPP_WIDTH'(4));

   // Configuration registers.
   always_comb begin
      bpp_in   = bpp_ff;
      total_in = total_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_BYTES_PER_PIXEL) begin
            bpp_in = csr_wdata[BPP_WIDTH-1:0];
         end else if (csr_index == CSR_TOTAL_PIXELS) begin
            total_in = csr_wdata;
         end
      end
   end

   // Phase and image count as they stand after a possible restart.
   always_comb begin
      phase_v      = phase_ff;
      image_left_v = image_left_ff;
      if (req_data.image_start) begin
         image_left_v = total_ff;
         phase_v      = (total_ff == '0) ? PH_DONE : PH_HEADER;
      end
   end

   // Header count, clamped to what is left of the image.
   always_comb begin
      header_count = {1'b0, req_data.stream_byte[6:0]} + RUN_WIDTH'(1);
      if (image_left_v < TOTAL_WIDTH'(header_count)) begin
         header_count = image_left_v[RUN_WIDTH-1:0];
      end
   end

   // Pixel assembly, one byte at a time, first byte in the low bits.
   assign assembly_next  = assembly_ff
                         | (PIXEL_WIDTH'(req_data.stream_byte) << {byte_index_ff, 3'b000});
   assign index_next     = byte_index_ff + 2'd1;
   assign pixel_complete = (index_next == 2'd0) || ({1'b0, index_next} >= bpp_ff);

   always_comb begin
      if (phase_v == PH_RAW) begin
         image_left_after  = image_left_v - TOTAL_WIDTH'(1);
         packet_left_after = packet_left_ff - RUN_WIDTH'(1);
      end else begin
         image_left_after  = image_left_v - TOTAL_WIDTH'(packet_left_ff);
         packet_left_after = '0;
      end
   end

   // Decode state machine.
   always_comb begin
      phase_in       = phase_ff;
      packet_left_in = packet_left_ff;
      byte_index_in  = byte_index_ff;
      assembly_in    = assembly_ff;
      image_left_in  = image_left_ff;
      cmd_push       = 1'b0;
      cmd_data.pixel      = assembly_next;
      cmd_data.count      = (phase_v == PH_RAW) ? RUN_WIDTH'(1) : packet_left_ff;
      cmd_data.image_done = (image_left_after == '0);
      if (accept) begin
         if (!bpp_ok) begin
            if (req_data.image_start) begin
               phase_in = PH_DONE;
            end
         end else begin
            phase_in      = phase_v;
            image_left_in = image_left_v;
            unique case (phase_v)
               PH_DONE: begin
               end
               PH_HEADER: begin
                  packet_left_in = header_count;
                  byte_index_in  = 2'd0;
                  assembly_in    = '0;
                  phase_in       = req_data.stream_byte[7] ? PH_RUN : PH_RAW;
               end
               PH_RUN, PH_RAW: begin
                  if (!pixel_complete) begin
                     byte_index_in = index_next;
                     assembly_in   = assembly_next;
                  end else begin
                     byte_index_in  = 2'd0;
                     assembly_in    = '0;
                     image_left_in  = image_left_after;
                     packet_left_in = packet_left_after;
                     cmd_push       = 1'b1;
                     if (packet_left_after == '0) begin
                        phase_in = (image_left_after == '0) ? PH_DONE : PH_HEADER;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff         <= BPP_RESET;
         total_ff       <= '0;
         phase_ff       <= PH_DONE;
         packet_left_ff <= '0;
         byte_index_ff  <= '0;
         assembly_ff    <= '0;
         image_left_ff  <= '0;
      end else begin
         bpp_ff         <= bpp_in;
         total_ff       <= total_in;
         phase_ff       <= phase_in;
         packet_left_ff <= packet_left_in;
         byte_index_ff  <= byte_index_in;
         assembly_ff    <= assembly_in;
         image_left_ff  <= image_left_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/tgarle_cmd_fifo.sv
`default_nettype none

module tgarle_cmd_fifo
   import tgarle_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_push,
   input  wire cmd_type cmd_data,
   output logic         cmd_full,
   output cmd_head_type cmd_head,
   input  wire logic    cmd_pop
);

   cmd_type                  entry_ff [CMD_DEPTH];
   logic [CMD_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_WIDTH-1:0] fill_ff, fill_in;
   logic                     do_push, do_pop;

   assign cmd_full      = (fill_ff == CMD_CNT_WIDTH'(CMD_DEPTH));
   assign cmd_head.valid = (fill_ff != '0);
   assign cmd_head.data  = entry_ff[rd_ptr_ff];
   assign do_push       = cmd_push && !cmd_full;
   assign do_pop        = cmd_pop && cmd_head.valid;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == CMD_PTR_WIDTH'(CMD_DEPTH - 1)) ? '0
                                                               : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == CMD_PTR_WIDTH'(CMD_DEPTH - 1)) ? '0
                                                               : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= cmd_data;
      end
   end

endmodule

`default_nettype wire

// File: hdl/tgarle_back.sv
`default_nettype none

module tgarle_back
   import tgarle_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cmd_head_type cmd_head,
   output logic              cmd_pop,
   output logic              rsp_empty,
   output rsp_type           rsp_data,
   input  wire logic         rsp_pop
);

   logic                   busy_ff, busy_in;
   logic [PIXEL_WIDTH-1:0] pixel_ff, pixel_in;
   logic [RUN_WIDTH-1:0]   left_ff, left_in;
   logic                   done_ff, done_in;
   logic                   out_valid_ff, out_valid_in;
   rsp_type                out_data_ff, out_data_in;

   logic                   src_valid;
   logic [PIXEL_WIDTH-1:0] src_pixel;
   logic [RUN_WIDTH-1:0]   src_left;
   logic                   src_done;
   logic                   out_free;
   logic                   pair;
   logic [RUN_WIDTH-1:0]   left_after;
   logic                   emit;

   // The current run, or the queue head when no run is under way.
   assign src_valid = busy_ff || cmd_head.valid;
   assign src_pixel = busy_ff ? pixel_ff : cmd_head.data.pixel;
   assign src_left  = busy_ff ? left_ff : cmd_head.data.count;
   assign src_done  = busy_ff ? done_ff : cmd_head.data.image_done;

   assign out_free   = !out_valid_ff || rsp_pop;
   assign emit       = src_valid && out_free;
   assign pair       = (src_left >= RUN_WIDTH'(2));
   assign left_after = src_left - (pair ? RUN_WIDTH'(2) : RUN_WIDTH'(1));
   assign cmd_pop    = emit && !busy_ff;

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Run expansion, two pixels per result while at least two are left, else one.
   always_comb begin
      busy_in      = busy_ff;
      pixel_in     = pixel_ff;
      left_in      = left_ff;
      done_in      = done_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_data_in  = out_data_ff;
      if (emit) begin
         busy_in                    = (left_after != '0);
         pixel_in                   = src_pixel;
         left_in                    = left_after;
         done_in                    = src_done;
         out_valid_in               = 1'b1;
         out_data_in.pixel_first    = src_pixel;
         out_data_in.pixel_second   = pair ? src_pixel : '0;
         out_data_in.pixel_count    = pair ? 2'd2 : 2'd1;
         out_data_in.last_of_packet = (left_after == '0);
         out_data_in.image_done     = (left_after == '0) && src_done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pixel_ff    <= pixel_in;
      left_ff     <= left_in;
      done_ff     <= done_in;
      out_data_ff <= out_data_in;
   end

endmodule

`default_nettype wire
